FILE: design/assert_macros.svh
// Assertion macros shared by the drop decider RTL.
// Each macro wraps one concurrent property clocked on clk_i and reset by rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CBDD_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CBDD_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/cbdd_pkg.sv
// Package for the CoDel/BLUE drop decider: sequencer states, event and
// register codes, and the constant functions that build the 1/sqrt ROM.
// Used by cbdd_mul and codel_blue_drop_decider_top; depends on nothing.
`default_nettype none

package cbdd_pkg;

  // Width of the shared multiplier operands.
  localparam int MulW = 32;

  // Event codes carried in the op field.
  localparam logic [1:0] OP_DEQUEUE = 2'd0;
  localparam logic [1:0] OP_FULL    = 2'd1;
  localparam logic [1:0] OP_EMPTY   = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_TARGET   = 2'd0;
  localparam logic [1:0] REG_INTERVAL = 2'd1;
  localparam logic [1:0] REG_BLUE_INC = 2'd2;
  localparam logic [1:0] REG_BLUE_DEC = 2'd3;

  // 3.0 in Q32.32 for the Newton step.
  localparam logic [63:0] THREE_Q32 = 64'h0000_0003_0000_0000;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_EVAL,
    S_UPD,
    S_N1,
    S_N2,
    S_N3,
    S_N4,
    S_N5,
    S_N6,
    S_LAW,
    S_ADV,
    S_CHK,
    S_DONE
  } state_e;

  // One Newton step of 1/sqrt(cnt) in Q0.32, with 64-bit wrapping.
  function automatic logic [31:0] newton_step(input logic [31:0] est,
                                              input logic [31:0] cnt);
    logic [63:0] prod;
    logic [31:0] sq;
    logic [63:0] v;
    prod = {32'b0, est} * {32'b0, est};
    sq   = prod[63:32];
    v    = THREE_Q32 - ({32'b0, cnt} * {32'b0, sq});
    v    = v >> 2;
    v    = (v * {32'b0, est}) >> 31;
    return v[31:0];
  endfunction

  // ROM entry k: all ones for zero, else four Newton steps from entry k-1.
  function automatic logic [31:0] inv_sqrt_entry(input int unsigned k);
    logic [31:0] est;
    est = '1;
    for (int unsigned j = 1; j <= k; j++) begin
      est = newton_step(est, 32'(j));
      est = newton_step(est, 32'(j));
      est = newton_step(est, 32'(j));
      est = newton_step(est, 32'(j));
    end
    return est;
  endfunction

endpackage

`default_nettype wire

FILE: design/cbdd_intf.sv
// Request and response channel interfaces of the drop decider.
// Valid/ready handshake with the event fields and the verdict fields.
// Depends on nothing.
`default_nettype none

interface cbdd_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [63:0] now_time;
  logic [63:0] enqueue_stamp;
  logic        ecn_capable;
  logic [31:0] random_value;

  modport source (output valid, output op, output now_time, output enqueue_stamp,
                  output ecn_capable, output random_value, input ready);
  modport sink (input valid, input op, input now_time, input enqueue_stamp,
                input ecn_capable, input random_value, output ready);
endinterface

interface cbdd_rsp_if;
  logic valid;
  logic ready;
  logic drop;
  logic ecn_mark;
  logic blue_change;

  modport source (output valid, output drop, output ecn_mark, output blue_change,
                  input ready);
  modport sink (input valid, input drop, input ecn_mark, input blue_change,
                output ready);
endinterface

`default_nettype wire

FILE: design/codel_blue_drop_decider_top.sv
// CoDel/BLUE drop decider.
// Each request on req_i is one queue event: a dequeued packet, a queue-full or a
// queue-empty indication, with the current time, the packet's enqueue stamp, its
// ECN capability and a random word. Each request yields exactly one response on
// rsp_o carrying drop, ecn_mark and blue_change. Configuration registers are
// written through cfg_we_i/cfg_idx_i/cfg_wdata_i; the user must write them only
// while no request is in flight, as the block does not enforce it. The block
// takes one request at a time: req_i.ready is high only while idle. Queue-full,
// queue-empty and dequeues that need no schedule step go from S_EVAL to S_DONE,
// which loads the response register and returns to idle in the same cycle. A
// schedule step runs S_UPD, S_N1 to S_N6, S_LAW and S_ADV when the drop count
// is at or above TABLE_DEPTH (one Newton step through the shared multiplier plus
// the control-law product) and S_UPD, S_LAW and S_ADV otherwise. The catch-up
// loop repeats a step, plus one S_CHK check, for each count it takes back.
// The response sits in an output register, so a new request is accepted while a
// response still waits; a stalled receiver holds the finished result in the
// sequencer until the register frees. Reset clears the control state and
// restores the register defaults; no clearing pass is needed.
`default_nettype none

`include "assert_macros.svh"

module codel_blue_drop_decider_top
  import cbdd_pkg::*;
#(
  parameter int TABLE_DEPTH = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  cbdd_req_if.sink         req_i,
  cbdd_rsp_if.source       rsp_o,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_wdata_i
);

  localparam int IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  // 1/sqrt ROM built at elaboration.
  logic [31:0] rom [TABLE_DEPTH];
  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_rom
    assign rom[k] = inv_sqrt_entry(k);
  end

  state_e state_q, state_d;

  // Latched request.
  logic [1:0]  op_q;
  logic [63:0] now_q, stamp_q;
  logic        ecn_q;
  logic [31:0] rnd_q;

  // Configuration registers.
  logic [31:0] target_q, interval_q, inc_q, dec_q;

  // Queue management state.
  logic [31:0] cnt_q, cnt_d;
  logic [31:0] est_q, est_d;
  logic [63:0] next_q, next_d;
  logic        dropping_q, dropping_d;
  logic [63:0] hold_q, hold_d;
  logic [31:0] prob_q, prob_d;
  logic        loop_q, loop_d;

  // Newton scratch.
  logic [61:0] v_q, v_d;
  logic [63:0] acc_q, acc_d;

  // Pending verdict and output register.
  logic res_drop_q, res_drop_d, res_mark_q, res_mark_d, res_chg_q, res_chg_d;
  logic out_valid_q, out_valid_d;
  logic out_drop_q, out_drop_d, out_mark_q, out_mark_d, out_chg_q, out_chg_d;

  // Shared multiplier.
  logic        mul_en;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;

  cbdd_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // Common comparisons.
  logic [63:0] sojourn, due_diff, hold_diff, newton_sum, v_full;
  logic [32:0] prob_sum;
  logic [31:0] prob_dec;
  logic        over, due, hold_over, blue_hit, out_free;

  assign sojourn    = now_q - stamp_q;
  assign due_diff   = now_q - next_q;
  assign hold_diff  = now_q - hold_q;
  assign over       = sojourn > {32'b0, target_q};
  assign due        = (cnt_q != '0) && !due_diff[63];
  assign hold_over  = hold_diff > {32'b0, target_q};
  assign blue_hit   = (prob_q != '0) && (rnd_q < prob_q);
  assign prob_sum   = {1'b0, prob_q} + {1'b0, inc_q};
  assign prob_dec   = (prob_q < dec_q) ? '0 : (prob_q - dec_q);
  assign newton_sum = acc_q + {prod[31:0], 32'b0};
  assign v_full     = THREE_Q32 - prod;
  assign out_free   = !out_valid_q || rsp_o.ready;

  assign req_i.ready = (state_q == S_IDLE);

  // Sequencer: next state, datapath updates and multiplier issue.
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    est_d      = est_q;
    next_d     = next_q;
    dropping_d = dropping_q;
    hold_d     = hold_q;
    prob_d     = prob_q;
    loop_d     = loop_q;
    v_d        = v_q;
    acc_d      = acc_q;
    res_drop_d = res_drop_q;
    res_mark_d = res_mark_q;
    res_chg_d  = res_chg_q;
    mul_en     = 1'b0;
    mul_a      = est_q;
    mul_b      = est_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_drop_d  = out_drop_q;
    out_mark_d  = out_mark_q;
    out_chg_d   = out_chg_q;

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          state_d = S_EVAL;
        end
      end

      S_EVAL: begin
        res_drop_d = 1'b0;
        res_mark_d = 1'b0;
        res_chg_d  = 1'b0;
        state_d    = S_DONE;
        case (op_q)
          OP_DEQUEUE: begin
            // Sojourn check enters or leaves the dropping state.
            if (over) begin
              dropping_d = 1'b1;
              if (!dropping_q) begin
                next_d = now_q + {32'b0, interval_q};
              end
              if (cnt_q == '0) begin
                cnt_d = 32'd1;
              end
            end else begin
              dropping_d = 1'b0;
            end
            // Scheduled drop, zero-interval reset or start of catch-up.
            if (due && over) begin
              res_mark_d = ecn_q;
              res_drop_d = !ecn_q;
              if (cnt_q != '1) begin
                cnt_d = cnt_q + 32'd1;
              end
              loop_d  = 1'b0;
              state_d = S_UPD;
            end else if (due && (interval_q == '0)) begin
              cnt_d = '0;
              est_d = rom[0];
            end else if (due) begin
              cnt_d   = cnt_q - 32'd1;
              loop_d  = 1'b1;
              state_d = S_UPD;
            end
            if (blue_hit) begin
              res_drop_d = 1'b1;
            end
          end
          OP_FULL: begin
            // Raise the BLUE probability after the hold-off.
            if (hold_over) begin
              res_chg_d = (prob_q == '0);
              prob_d    = prob_sum[32] ? '1 : prob_sum[31:0];
              hold_d    = now_q;
            end
            dropping_d = 1'b1;
            next_d     = now_q;
            if (cnt_q == '0) begin
              cnt_d = 32'd1;
            end
          end
          OP_EMPTY: begin
            // Lower the BLUE probability after the hold-off.
            if ((prob_q != '0) && hold_over) begin
              prob_d    = prob_dec;
              hold_d    = now_q;
              res_chg_d = (prob_dec == '0);
            end
            dropping_d = 1'b0;
          end
          default: begin
          end
        endcase
      end

      S_UPD: begin
        // Small counts read the ROM; larger ones take a Newton step.
        if (cnt_q < 32'(TABLE_DEPTH)) begin
          est_d   = rom[cnt_q[IdxW-1:0]];
          state_d = S_LAW;
        end else begin
          state_d = S_N1;
        end
      end

      S_N1: begin
        mul_en  = 1'b1;
        state_d = S_N2;
      end

      S_N2: begin
        mul_en  = 1'b1;
        mul_a   = cnt_q;
        mul_b   = prod[63:32];
        state_d = S_N3;
      end

      S_N3: begin
        v_d     = v_full[63:2];
        state_d = S_N4;
      end

      S_N4: begin
        mul_en  = 1'b1;
        mul_a   = v_q[31:0];
        state_d = S_N5;
      end

      S_N5: begin
        mul_en  = 1'b1;
        mul_a   = {2'b0, v_q[61:32]};
        acc_d   = prod;
        state_d = S_N6;
      end

      S_N6: begin
        est_d   = newton_sum[62:31];
        state_d = S_LAW;
      end

      S_LAW: begin
        mul_en  = 1'b1;
        mul_a   = interval_q;
        state_d = S_ADV;
      end

      S_ADV: begin
        next_d  = next_q + {32'b0, prod[63:32]};
        state_d = loop_q ? S_CHK : S_DONE;
      end

      S_CHK: begin
        // Catch-up continues while the schedule is still due.
        if (due) begin
          cnt_d   = cnt_q - 32'd1;
          state_d = S_UPD;
        end else begin
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_drop_d  = res_drop_q;
          out_mark_d  = res_mark_q;
          out_chg_d   = res_chg_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Sequencer and control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      est_q       <= '0;
      next_q      <= '0;
      dropping_q  <= 1'b0;
      hold_q      <= '0;
      prob_q      <= '0;
      loop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      est_q       <= est_d;
      next_q      <= next_d;
      dropping_q  <= dropping_d;
      hold_q      <= hold_d;
      prob_q      <= prob_d;
      loop_q      <= loop_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q   <= 32'd5000000;
      interval_q <= 32'd100000000;
      inc_q      <= 32'd16777216;
      dec_q      <= 32'd1048576;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TARGET:   target_q   <= cfg_wdata_i;
        REG_INTERVAL: interval_q <= cfg_wdata_i;
        REG_BLUE_INC: inc_q      <= cfg_wdata_i;
        REG_BLUE_DEC: dec_q      <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // Payload registers: request capture, scratch and verdicts.
  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      op_q    <= req_i.op;
      now_q   <= req_i.now_time;
      stamp_q <= req_i.enqueue_stamp;
      ecn_q   <= req_i.ecn_capable;
      rnd_q   <= req_i.random_value;
    end
    v_q        <= v_d;
    acc_q      <= acc_d;
    res_drop_q <= res_drop_d;
    res_mark_q <= res_mark_d;
    res_chg_q  <= res_chg_d;
    out_drop_q <= out_drop_d;
    out_mark_q <= out_mark_d;
    out_chg_q  <= out_chg_d;
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.drop        = out_drop_q;
  assign rsp_o.ecn_mark    = out_mark_q;
  assign rsp_o.blue_change = out_chg_q;

  // An accepted request always moves the sequencer to evaluation.
  `CBDD_ASSERT_NXT(a_accept_eval, req_i.valid && req_i.ready, state_q == S_EVAL, "accept did not start evaluation")
  // The Newton path is only taken for counts beyond the ROM.
  `CBDD_ASSERT_IMP(a_newton_range, state_q == S_N1, cnt_q >= 32'(TABLE_DEPTH), "Newton step on a ROM count")
  // The dropping state always carries a nonzero count.
  `CBDD_ASSERT_IMP(a_dropping_count, dropping_q, cnt_q != '0, "dropping with zero count")
  // The BLUE probability changes only while an event is evaluated.
  `CBDD_ASSERT_NXT(a_prob_stable, state_q != S_EVAL, $stable(prob_q), "probability changed outside evaluation")

endmodule

`default_nettype wire

FILE: design/cbdd_mul.sv
// Shared 32x32 multiplier of the drop decider with a registered product.
// Depends on cbdd_pkg for the operand width.
`default_nettype none

module cbdd_mul
  import cbdd_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              en_i,
  input  wire logic [MulW-1:0]   a_i,
  input  wire logic [MulW-1:0]   b_i,
  output logic      [2*MulW-1:0] prod_o
);

  logic [2*MulW-1:0] prod_q;

  // Capture the full product when the sequencer issues an operation.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= {{MulW{1'b0}}, a_i} * {{MulW{1'b0}}, b_i};
    end
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

FILE: test/codel_blue_drop_decider_top_tb.sv
// Testbench for the CoDel/BLUE drop decider top level.
// Drives queue events through the request channel, predicts each verdict in
// place, and compares it field by field; needs cbdd_pkg, the channel interfaces and the RTL.
`timescale 1ns / 1ps

module codel_blue_drop_decider_top_tb
  import cbdd_pkg::*;
();

  localparam int          RomDepth   = 16;
  localparam int unsigned StallLimit = 50000;
  localparam logic [1:0]  OP_UNUSED  = 2'd3;

  // One queue event as offered on the request channel.
  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] now_time;
    logic [63:0] enqueue_stamp;
    logic        ecn_capable;
    logic [31:0] random_value;
  } aqm_event_t;

  // One verdict as returned on the response channel.
  typedef struct packed {
    logic drop;
    logic ecn_mark;
    logic blue_change;
  } verdict_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [31:0] cfg_wdata_i;

  cbdd_req_if req_if ();
  cbdd_rsp_if rsp_if ();

  codel_blue_drop_decider_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_if),
    .rsp_o      (rsp_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // Register copies held by the predictor.
  logic [31:0] cfg_target;
  logic [31:0] cfg_interval;
  logic [31:0] cfg_inc;
  logic [31:0] cfg_dec;

  // Predicted scheduler and BLUE state.
  logic [31:0] codel_cnt;
  logic [31:0] inv_root;
  logic [63:0] next_drop_at;
  logic        in_drop_state;
  logic [63:0] blue_last_change;
  logic [31:0] p_drop;
  logic [31:0] root_rom [RomDepth];

  verdict_t    pending_verdicts [$];
  int unsigned mismatches;
  int unsigned idle_cycles;
  int unsigned rsp_hold_req;
  bit          gaps_on;
  bit          congested;
  logic [63:0] traffic_now;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // One Newton refinement of 1/sqrt(cnt) in Q0.32; everything wraps at 64 bits.
  function automatic logic [31:0] newton_refine(input logic [31:0] est,
                                                input logic [31:0] cnt);
    logic [63:0] sq;
    logic [63:0] v;
    sq = ({32'b0, est} * {32'b0, est}) >> 32;
    v  = (64'd3 << 32) - {32'b0, cnt} * sq;
    v  = v >> 2;
    v  = (v * {32'b0, est}) >> 31;
    return v[31:0];
  endfunction

  function automatic bit sched_due(input logic [63:0] now);
    logic [63:0] d;
    d = now - next_drop_at;
    return (codel_cnt != 32'd0) && !d[63];
  endfunction

  function automatic void refresh_root();
    if (codel_cnt < RomDepth) inv_root = root_rom[codel_cnt[3:0]];
    else inv_root = newton_refine(inv_root, codel_cnt);
  endfunction

  function automatic void advance_schedule();
    next_drop_at = next_drop_at + (({32'b0, cfg_interval} * {32'b0, inv_root}) >> 32);
  endfunction

  // Apply one event to the predicted state and return the verdict it yields.
  function automatic verdict_t predict_verdict(input aqm_event_t ev);
    verdict_t    v;
    logic [63:0] tgt;
    bit          over;
    bit          due;
    v   = '0;
    tgt = {32'b0, cfg_target};
    case (ev.op)
      OP_DEQUEUE: begin
        over = (ev.now_time - ev.enqueue_stamp) > tgt;
        due  = sched_due(ev.now_time);
        if (over) begin
          if (!in_drop_state) begin
            in_drop_state = 1'b1;
            next_drop_at  = ev.now_time + {32'b0, cfg_interval};
          end
          if (codel_cnt == 32'd0) codel_cnt = 32'd1;
        end else begin
          in_drop_state = 1'b0;
        end
        if (due && in_drop_state) begin
          v.ecn_mark = ev.ecn_capable;
          v.drop     = !ev.ecn_capable;
          if (codel_cnt != 32'hFFFF_FFFF) codel_cnt = codel_cnt + 32'd1;
          refresh_root();
          advance_schedule();
        end else if (due && cfg_interval == 32'd0) begin
          // The catch-up loop cannot advance the schedule and runs out the count.
          codel_cnt = 32'd0;
          inv_root  = root_rom[0];
        end else begin
          while (due) begin
            codel_cnt = codel_cnt - 32'd1;
            refresh_root();
            advance_schedule();
            due = sched_due(ev.now_time);
          end
        end
        if (p_drop != 32'd0 && ev.random_value < p_drop) v.drop = 1'b1;
      end
      OP_FULL: begin
        if ((ev.now_time - blue_last_change) > tgt) begin
          v.blue_change    = (p_drop == 32'd0);
          p_drop           = p_drop + cfg_inc;
          if (p_drop < cfg_inc) p_drop = 32'hFFFF_FFFF;
          blue_last_change = ev.now_time;
        end
        in_drop_state = 1'b1;
        next_drop_at  = ev.now_time;
        if (codel_cnt == 32'd0) codel_cnt = 32'd1;
      end
      OP_EMPTY: begin
        if (p_drop != 32'd0 && (ev.now_time - blue_last_change) > tgt) begin
          if (p_drop < cfg_dec) p_drop = 32'd0;
          else p_drop = p_drop - cfg_dec;
          blue_last_change = ev.now_time;
          v.blue_change    = (p_drop == 32'd0);
        end
        in_drop_state = 1'b0;
      end
      default: ;
    endcase
    return v;
  endfunction

  // Predicted state after reset, including the 1/sqrt ROM.
  function automatic void reset_predictor();
    logic [31:0] est;
    cfg_target       = 32'd5_000_000;
    cfg_interval     = 32'd100_000_000;
    cfg_inc          = 32'd16_777_216;
    cfg_dec          = 32'd1_048_576;
    codel_cnt        = '0;
    inv_root         = '0;
    next_drop_at     = '0;
    in_drop_state    = 1'b0;
    blue_last_change = '0;
    p_drop           = '0;
    est              = 32'hFFFF_FFFF;
    root_rom[0]      = est;
    for (int k = 1; k < RomDepth; k++) begin
      repeat (4) est = newton_refine(est, 32'(k));
      root_rom[k] = est;
    end
  endfunction

  // Mostly no idling, some short gaps, a few long ones.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 70) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offer one request and record its verdict once it is accepted.
  task automatic send_event(input aqm_event_t ev);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      req_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    req_if.valid         <= 1'b1;
    req_if.op            <= ev.op;
    req_if.now_time      <= ev.now_time;
    req_if.enqueue_stamp <= ev.enqueue_stamp;
    req_if.ecn_capable   <= ev.ecn_capable;
    req_if.random_value  <= ev.random_value;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    pending_verdicts.push_back(predict_verdict(ev));
  endtask

  task automatic send_fields(input logic [1:0] op, input logic [63:0] now,
                             input logic [63:0] stamp, input logic ecn,
                             input logic [31:0] rnd);
    aqm_event_t ev;
    ev.op            = op;
    ev.now_time      = now;
    ev.enqueue_stamp = stamp;
    ev.ecn_capable   = ecn;
    ev.random_value  = rnd;
    send_event(ev);
  endtask

  // Stop offering and wait until every verdict is back and the sequencer is idle.
  task automatic drain_block();
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic program_reg(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      REG_TARGET:   cfg_target   = val;
      REG_INTERVAL: cfg_interval = val;
      REG_BLUE_INC: cfg_inc      = val;
      REG_BLUE_DEC: cfg_dec      = val;
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [31:0] tgt, input logic [31:0] ivl,
                              input logic [31:0] inc, input logic [31:0] dec);
    program_reg(REG_TARGET, tgt);
    program_reg(REG_INTERVAL, ivl);
    program_reg(REG_BLUE_INC, inc);
    program_reg(REG_BLUE_DEC, dec);
  endtask

  // Build a traffic event: a running clock with congestion episodes,
  // plus a small share of fully random noise.
  task automatic make_traffic_event(output aqm_event_t ev);
    logic [63:0] span;
    logic [63:0] soj;
    logic [63:0] tgt;
    int unsigned r;
    tgt = {32'b0, cfg_target};
    r   = $urandom_range(0, 99);
    if (r < 8) begin
      ev.op            = 2'($urandom_range(0, 3));
      ev.now_time      = {$urandom, $urandom};
      ev.enqueue_stamp = {$urandom, $urandom};
    end else begin
      if ($urandom_range(0, 29) == 0) congested = !congested;
      span = {32'b0, cfg_interval} / 2 + tgt / 2 + 64'd8;
      if ($urandom_range(0, 19) == 0) traffic_now = traffic_now + span * 8;
      else traffic_now = traffic_now + {$urandom, $urandom} % span;
      if (congested) soj = tgt + 64'd1 + {$urandom, $urandom} % (tgt + 64'd16);
      else soj = {$urandom, $urandom} % (tgt + 64'd1);
      r = $urandom_range(0, 99);
      if (r < 70) ev.op = OP_DEQUEUE;
      else if (r < 84) ev.op = OP_FULL;
      else if (r < 98) ev.op = OP_EMPTY;
      else ev.op = OP_UNUSED;
      ev.now_time      = traffic_now;
      ev.enqueue_stamp = traffic_now - soj;
    end
    ev.ecn_capable  = 1'($urandom_range(0, 1));
    ev.random_value = $urandom;
  endtask

  // Schedule start, drops, marks, catch-up, BLUE steps and time wrap at defaults.
  task automatic test_directed_events();
    program_regs(32'd5_000_000, 32'd100_000_000, 32'd16_777_216, 32'd1_048_576);
    send_fields(OP_DEQUEUE, 64'd0, 64'd0, 1'b0, '1);
    send_fields(OP_DEQUEUE, 64'd10_000_000, 64'd0, 1'b0, '1);
    send_fields(OP_DEQUEUE, 64'd110_000_001, 64'd100_000_000, 1'b0, '1);
    send_fields(OP_DEQUEUE, 64'd300_000_000, 64'd290_000_000, 1'b1, '1);
    send_fields(OP_DEQUEUE, 64'd301_000_000, 64'd296_000_000, 1'b0, '1);
    send_fields(OP_DEQUEUE, 64'd900_000_000, 64'd899_000_000, 1'b0, '1);
    send_fields(OP_FULL, 64'd1_000_000_000, 64'd0, 1'b0, '0);
    send_fields(OP_FULL, 64'd1_000_000_001, 64'd0, 1'b1, '0);
    send_fields(OP_DEQUEUE, 64'd1_000_000_002, 64'd1_000_000_002, 1'b1, 32'd0);
    send_fields(OP_DEQUEUE, 64'd1_000_000_003, 64'd0, 1'b0, '1);
    send_fields(OP_EMPTY, 64'd1_010_000_000, 64'd0, 1'b0, '0);
    send_fields(OP_EMPTY, 64'd1_010_000_001, 64'd0, 1'b0, '0);
    send_fields(OP_UNUSED, '1, '1, 1'b1, '1);
    send_fields(OP_DEQUEUE, '1, '1, 1'b1, '1);
    send_fields(OP_DEQUEUE, 64'd0, '1, 1'b0, '0);
    send_fields(OP_DEQUEUE, 64'd0, 64'd1, 1'b1, 32'd0);
    send_fields(OP_DEQUEUE, 64'h8000_0000_0000_0000, 64'd0, 1'b0, 32'h8000_0000);
    send_fields(OP_FULL, '1, 64'd0, 1'b0, '0);
    send_fields(OP_EMPTY, 64'h7FFF_FFFF_FFFF_FFFF, '1, 1'b1, '1);
    drain_block();
  endtask

  // Register extremes: probability saturation at both ends and the zero interval.
  task automatic test_saturation_limits();
    logic [63:0] t;
    t = 64'h0000_0100_0000_0000;
    program_regs(32'd0, 32'd0, '1, '1);
    send_fields(OP_FULL, t, 64'd0, 1'b0, '0);
    send_fields(OP_FULL, t + 1, 64'd0, 1'b0, '0);
    send_fields(OP_EMPTY, t + 2, 64'd0, 1'b0, '0);
    send_fields(OP_DEQUEUE, t + 3, t + 3, 1'b0, '1);
    send_fields(OP_FULL, t + 4, 64'd0, 1'b0, '0);
    send_fields(OP_DEQUEUE, t + 5, t + 4, 1'b0, 32'hFFFF_FFFE);
    send_fields(OP_DEQUEUE, t + 6, t + 5, 1'b1, '1);
    send_fields(OP_EMPTY, t + 7, 64'd0, 1'b0, '0);
    send_fields(OP_EMPTY, t + 8, 64'd0, 1'b0, '0);
    drain_block();
    program_regs('1, '1, 32'd1, 32'd0);
    send_fields(OP_FULL, t + 9, 64'd0, 1'b0, '0);
    send_fields(OP_FULL, t + (64'd1 << 33), 64'd0, 1'b0, '0);
    send_fields(OP_EMPTY, t + (64'd1 << 34), 64'd0, 1'b0, '0);
    send_fields(OP_DEQUEUE, t + (64'd1 << 35), t + (64'd1 << 35) - (64'd1 << 32),
                1'b0, 32'd0);
    drain_block();
  endtask

  // Random traffic under one register setting.
  task automatic test_random_traffic(input logic [31:0] tgt, input logic [31:0] ivl,
                                     input logic [31:0] inc, input logic [31:0] dec,
                                     input int unsigned count, input bit with_gaps);
    aqm_event_t  ev;
    int unsigned sent;
    program_regs(tgt, ivl, inc, dec);
    gaps_on = with_gaps;
    sent    = 0;
    while (sent < count) begin
      make_traffic_event(ev);
      send_event(ev);
      if (ev.op != OP_UNUSED) sent++;
    end
    drain_block();
    gaps_on = 1'b1;
  endtask

  // The receiver holds off for a long stretch while requests keep coming.
  task automatic test_backpressure();
    aqm_event_t ev;
    program_regs(32'd2000, 32'd50_000, 32'h0800_0000, 32'h0200_0000);
    gaps_on      = 1'b0;
    rsp_hold_req = 300;
    repeat (30) begin
      make_traffic_event(ev);
      send_event(ev);
    end
    drain_block();
    gaps_on = 1'b1;
  endtask

  // Response side: random stalls, or a long hold when one is requested.
  initial begin : verdict_sink
    int unsigned stall;
    stall        = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rsp_hold_req != 0) begin
        stall        = rsp_hold_req;
        rsp_hold_req = 0;
      end else if (stall == 0) begin
        stall = pick_gap();
      end
      if (stall != 0) begin
        rsp_if.ready <= 1'b0;
        stall--;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Compare each accepted response with the oldest predicted verdict.
  always @(posedge clk_i) begin : verdict_check
    verdict_t want;
    if (rst_ni && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected response drop=%0b ecn_mark=%0b blue_change=%0b",
                 $time, rsp_if.drop, rsp_if.ecn_mark, rsp_if.blue_change);
        mismatches++;
      end else begin
        want = pending_verdicts.pop_front();
        if (rsp_if.drop !== want.drop) begin
          $display("%0t: drop expected %0b actual %0b", $time, want.drop, rsp_if.drop);
          mismatches++;
        end
        if (rsp_if.ecn_mark !== want.ecn_mark) begin
          $display("%0t: ecn_mark expected %0b actual %0b",
                   $time, want.ecn_mark, rsp_if.ecn_mark);
          mismatches++;
        end
        if (rsp_if.blue_change !== want.blue_change) begin
          $display("%0t: blue_change expected %0b actual %0b",
                   $time, want.blue_change, rsp_if.blue_change);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: end the run when no request or response moves for too long.
  always @(posedge clk_i) begin
    if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
        (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= StallLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : run
    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_idx_i            = REG_TARGET;
    cfg_wdata_i          = '0;
    req_if.valid         = 1'b0;
    req_if.op            = OP_DEQUEUE;
    req_if.now_time      = '0;
    req_if.enqueue_stamp = '0;
    req_if.ecn_capable   = 1'b0;
    req_if.random_value  = '0;
    mismatches           = 0;
    idle_cycles          = 0;
    rsp_hold_req         = 0;
    gaps_on              = 1'b1;
    congested            = 1'b0;
    traffic_now          = {$urandom, $urandom};
    reset_predictor();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_events();
    test_saturation_limits();
    test_random_traffic(32'd5_000_000, 32'd100_000_000, 32'd16_777_216, 32'd1_048_576,
                        220, 1'b1);
    test_random_traffic(32'd1000, 32'd20_000, 32'h1000_0000, 32'h0400_0000, 160, 1'b0);
    test_random_traffic('1, '1, 32'd1, 32'd0, 80, 1'b1);
    test_random_traffic(32'd0, 32'd0, 32'd0, 32'd0, 60, 1'b1);
    test_random_traffic($urandom_range(0, 2_000_000), $urandom_range(0, 50_000_000),
                        $urandom, $urandom, 150, 1'b1);
    test_backpressure();

    if (mismatches == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
